FILE: rtl/bmhq_pkg.sv
// ============================================================================
// bmhq_pkg - shared types and constants for the binary min-heap queue
// Key and field widths, action and status codes, payload structs and the
// command/status bundles between controller and datapath.
// ============================================================================
package bmhq_pkg;

   // heap size and derived widths
   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int POS_W    = ADDR_W + 2;

   // payload field widths
   localparam int ACTION_W = 2;
   localparam int KEY_W    = 31;
   localparam int TOTAL_W  = 5;
   localparam int STATUS_W = 2;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [KEY_W-1:0]    new_key;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0]    popped_key;
      logic [KEY_W-1:0]    min_key;
      logic [TOTAL_W-1:0]  entry_total;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // memory read address select
   typedef enum logic [2:0] {
      RD_NONE,
      RD_ROOT,
      RD_LAST,
      RD_PARENT,
      RD_LEFT,
      RD_RIGHT
   } rd_sel_type;

   // memory write select: what goes into the hole at the current position
   typedef enum logic [1:0] {
      WR_NONE,
      WR_KEY,
      WR_PARENT,
      WR_CHILD
   } wr_sel_type;

   typedef struct packed {
      logic                init;          // clear popped key, load status code
      logic [STATUS_W-1:0] status_code;
      logic                key_from_req;
      logic                pos_from_cnt;
      logic                pos_zero;
      logic                cnt_inc;
      logic                cnt_dec;
      logic                cnt_clr;
      logic                cap_popped;
      logic                cap_key;
      logic                cap_child;
      rd_sel_type          rd_sel;
      wr_sel_type          wr_sel;
      logic                load_rsp;
   } bmhq_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic pos_zero;
      logic left_ok;
      logic up_move;
      logic down_move;
      logic rsp_free;
   } bmhq_sts_type;

endpackage

FILE: rtl/bmhq_dpath.sv
// ============================================================================
// bmhq_dpath - heap datapath
// Key memory, moving key, hole position, entry count, compare logic and the
// result register.
// ============================================================================
module bmhq_dpath import bmhq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [KEY_W-1:0] req_key,
   input  bmhq_cmd_type     cmd,
   output bmhq_sts_type     sts,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output rsp_type          rsp_data
);

   logic [KEY_W-1:0]    mem [CAPACITY];
   logic [KEY_W-1:0]    rdata_ff;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [KEY_W-1:0]    child_ff, child_in;
   logic [KEY_W-1:0]    popped_ff, popped_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [POS_W-1:0]    left_pos, right_pos, count_ext;
   logic [ADDR_W-1:0]   parent_pos, chosen_pos, rd_addr;
   logic                left_ok, right_ok, pick_right, rd_en, wr_en;
   logic [KEY_W-1:0]    chosen_key, wr_data;

   // tree geometry around the hole
   always_comb begin
      left_pos   = {1'b0, pos_ff, 1'b1};
      right_pos  = left_pos + POS_W'(1);
      count_ext  = POS_W'(count_ff);
      left_ok    = left_pos < count_ext;
      right_ok   = right_pos < count_ext;
      parent_pos = (pos_ff - ADDR_W'(1)) >> 1;
      // right child wins only when strictly smaller
      pick_right = right_ok && (rdata_ff < child_ff);
      chosen_key = pick_right ? rdata_ff : child_ff;
      chosen_pos = pick_right ? right_pos[ADDR_W-1:0] : left_pos[ADDR_W-1:0];
   end

   always_comb begin
      rd_en = 1'b1;
      case (cmd.rd_sel)
         RD_ROOT:   rd_addr = '0;
         RD_LAST:   rd_addr = count_ff[ADDR_W-1:0];
         RD_PARENT: rd_addr = parent_pos;
         RD_LEFT:   rd_addr = left_pos[ADDR_W-1:0];
         RD_RIGHT:  rd_addr = right_pos[ADDR_W-1:0];
         default: begin
            rd_addr = '0;
            rd_en   = 1'b0;
         end
      endcase
   end

   always_comb begin
      wr_en  = 1'b1;
      pos_in = pos_ff;
      case (cmd.wr_sel)
         WR_KEY:    wr_data = key_ff;
         WR_PARENT: begin
            wr_data = rdata_ff;
            pos_in  = parent_pos;
         end
         WR_CHILD: begin
            wr_data = chosen_key;
            pos_in  = chosen_pos;
         end
         default: begin
            wr_data = key_ff;
            wr_en   = 1'b0;
         end
      endcase
      if (cmd.pos_from_cnt) begin
         pos_in = count_ff[ADDR_W-1:0];
      end else if (cmd.pos_zero) begin
         pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[pos_ff] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_clr) begin
         count_in = '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end

      key_in = key_ff;
      if (cmd.key_from_req) begin
         key_in = req_key;
      end else if (cmd.cap_key) begin
         key_in = rdata_ff;
      end

      child_in  = cmd.cap_child ? rdata_ff : child_ff;

      popped_in = popped_ff;
      status_in = status_ff;
      if (cmd.init) begin
         popped_in = '0;
         status_in = cmd.status_code;
      end else if (cmd.cap_popped) begin
         popped_in = rdata_ff;
      end

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_rsp) begin
         rsp_in.popped_key  = popped_ff;
         rsp_in.min_key     = (count_ff != '0) ? rdata_ff : '0;
         rsp_in.entry_total = TOTAL_W'(count_ff);
         rsp_in.status      = status_ff;
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff    <= pos_in;
      key_ff    <= key_in;
      child_ff  <= child_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      sts.full      = count_ff == CNT_W'(CAPACITY);
      sts.empty     = count_ff == '0;
      sts.pos_zero  = pos_ff == '0;
      sts.left_ok   = left_ok;
      sts.up_move   = rdata_ff > key_ff;
      sts.down_move = chosen_key < key_ff;
      sts.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/bmhq_ctrl.sv
// ============================================================================
// bmhq_ctrl - heap sequencer
// One-hot state machine that steps the datapath through sift-up, sift-down
// and the final root read.
// ============================================================================
module bmhq_ctrl import bmhq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [ACTION_W-1:0] req_action,
   output logic                req_stall,
   input  bmhq_sts_type        sts,
   output bmhq_cmd_type        cmd
);

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b00_0000_0001,
      ST_DEL_ROOT = 10'b00_0000_0010,
      ST_DEL_LAST = 10'b00_0000_0100,
      ST_DN_LEFT  = 10'b00_0000_1000,
      ST_DN_RIGHT = 10'b00_0001_0000,
      ST_DN_CMP   = 10'b00_0010_0000,
      ST_UP_CHK   = 10'b00_0100_0000,
      ST_UP_CMP   = 10'b00_1000_0000,
      ST_FIN_RD   = 10'b01_0000_0000,
      ST_FIN      = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in        = state_ff;
      req_stall       = 1'b1;
      cmd             = '0;
      cmd.status_code = STATUS_DONE;
      cmd.rd_sel      = RD_NONE;
      cmd.wr_sel      = WR_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.init = 1'b1;
               state_in = ST_FIN_RD;
               case (req_action)
                  ACT_INSERT: begin
                     if (sts.full) begin
                        cmd.status_code = STATUS_FULL;
                     end else begin
                        cmd.key_from_req = 1'b1;
                        cmd.pos_from_cnt = 1'b1;
                        cmd.cnt_inc      = 1'b1;
                        state_in         = ST_UP_CHK;
                     end
                  end
                  ACT_DELETE: begin
                     if (sts.empty) begin
                        cmd.status_code = STATUS_EMPTY;
                     end else begin
                        cmd.cnt_dec  = 1'b1;
                        cmd.pos_zero = 1'b1;
                        cmd.rd_sel   = RD_ROOT;
                        state_in     = ST_DEL_ROOT;
                     end
                  end
                  ACT_CLEAR: begin
                     cmd.cnt_clr = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DEL_ROOT: begin
            cmd.cap_popped = 1'b1;
            cmd.rd_sel     = RD_LAST;
            state_in       = ST_DEL_LAST;
         end
         ST_DEL_LAST: begin
            cmd.cap_key = 1'b1;
            state_in    = ST_DN_LEFT;
         end
         ST_DN_LEFT: begin
            if (sts.left_ok) begin
               cmd.rd_sel = RD_LEFT;
               state_in   = ST_DN_RIGHT;
            end else begin
               cmd.wr_sel = WR_KEY;
               state_in   = ST_FIN_RD;
            end
         end
         ST_DN_RIGHT: begin
            cmd.cap_child = 1'b1;
            cmd.rd_sel    = RD_RIGHT;
            state_in      = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            if (sts.down_move) begin
               cmd.wr_sel = WR_CHILD;
               state_in   = ST_DN_LEFT;
            end else begin
               cmd.wr_sel = WR_KEY;
               state_in   = ST_FIN_RD;
            end
         end
         ST_UP_CHK: begin
            if (sts.pos_zero) begin
               cmd.wr_sel = WR_KEY;
               state_in   = ST_FIN_RD;
            end else begin
               cmd.rd_sel = RD_PARENT;
               state_in   = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (sts.up_move) begin
               cmd.wr_sel = WR_PARENT;
               state_in   = ST_UP_CHK;
            end else begin
               cmd.wr_sel = WR_KEY;
               state_in   = ST_FIN_RD;
            end
         end
         ST_FIN_RD: begin
            cmd.rd_sel = RD_ROOT;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/binary_min_heap_queue_core.sv
// ============================================================================
// binary_min_heap_queue_core - fixed-capacity binary min-heap of 31-bit keys
// Insert, delete-minimum and clear; one response per request.
// ============================================================================
// Each request carries an action (insert, delete minimum, clear) and a key.
// The block answers every request with one response: the key popped by a
// delete (else 0), the root key afterwards (0 when empty), the entry count
// and a status (done, delete on empty heap, insert on full heap). Requests
// are handled one at a time. Timing is set by the key memory, which has one
// read port and one write port and gives one read per cycle: an insert moves
// the new key up one level per parent read and compare; a delete reads the
// root and the last key, then moves that key down one level per left read,
// right read and compare. Every request ends with a root read and the load
// of the response register, which waits while that register stays blocked.
// A new request is taken while the previous response still waits in the
// output register.
// ============================================================================
module binary_min_heap_queue_core import bmhq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   bmhq_cmd_type cmd;
   bmhq_sts_type sts;

   // sequencer: decides branch per action and walks the sift loops
   bmhq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath: key memory, hole position, count and response register
   bmhq_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_key   (req_data.new_key),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
